/* sv/rfkey_pkg.sv */
package rfkey_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CODE_WIDTH      = 8;
    localparam int KEY_WIDTH       = 3;
    localparam int KIND_WIDTH      = 2;
    localparam int REG_IDX_WIDTH   = 3;

    // register indexes
    localparam logic [REG_IDX_WIDTH-1:0] REG_SUSTAIN    = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_HOLD_START = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD     = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DEBOUNCE   = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CODE_UP    = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CODE_DOWN  = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CODE_POWER = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CODE_MODE  = 3'd7;

    // reset values
    localparam logic [CFG_WIDTH-1:0]  RST_SUSTAIN    = 16'd20;
    localparam logic [CFG_WIDTH-1:0]  RST_HOLD_START = 16'd100;
    localparam logic [CFG_WIDTH-1:0]  RST_PERIOD     = 16'd30;
    localparam logic [CODE_WIDTH-1:0] RST_DEBOUNCE   = 8'd1;
    localparam logic [CODE_WIDTH-1:0] RST_CODE_UP    = 8'h2E;
    localparam logic [CODE_WIDTH-1:0] RST_CODE_DOWN  = 8'h4C;
    localparam logic [CODE_WIDTH-1:0] RST_CODE_POWER = 8'h5B;
    localparam logic [CODE_WIDTH-1:0] RST_CODE_MODE  = 8'h3D;

    // key ids
    localparam logic [KEY_WIDTH-1:0] KEY_NONE  = 3'd0;
    localparam logic [KEY_WIDTH-1:0] KEY_UP    = 3'd1;
    localparam logic [KEY_WIDTH-1:0] KEY_DOWN  = 3'd2;
    localparam logic [KEY_WIDTH-1:0] KEY_POWER = 3'd3;
    localparam logic [KEY_WIDTH-1:0] KEY_MODE  = 3'd4;

    // event kinds
    localparam logic [KIND_WIDTH-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_WIDTH-1:0] EV_HOLD    = 2'd2;

    typedef struct packed {
        logic [CFG_WIDTH-1:0]            sustain;
        logic [CFG_WIDTH-1:0]            hold_start;
        logic [CFG_WIDTH-1:0]            period;
        logic [CODE_WIDTH-1:0]           debounce;
        logic [3:0][CODE_WIDTH-1:0]      code;
    } rfkey_cfg_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]  key_id;
        logic [KIND_WIDTH-1:0] event_kind;
        logic                  last;
    } rfkey_event_t;

    typedef struct packed {
        logic [1:0]   count;
        rfkey_event_t ev0;
        rfkey_event_t ev1;
    } rfkey_res_t;

endpackage

/* sv/rfkey_cfg.sv */
module rfkey_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rfkey_pkg::REG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [rfkey_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    output rfkey_pkg::rfkey_cfg_t                cfg
);

    rfkey_pkg::rfkey_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sustain    <= rfkey_pkg::RST_SUSTAIN;
            cfg_reg.hold_start <= rfkey_pkg::RST_HOLD_START;
            cfg_reg.period     <= rfkey_pkg::RST_PERIOD;
            cfg_reg.debounce   <= rfkey_pkg::RST_DEBOUNCE;
            cfg_reg.code[0]    <= rfkey_pkg::RST_CODE_UP;
            cfg_reg.code[1]    <= rfkey_pkg::RST_CODE_DOWN;
            cfg_reg.code[2]    <= rfkey_pkg::RST_CODE_POWER;
            cfg_reg.code[3]    <= rfkey_pkg::RST_CODE_MODE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfkey_pkg::REG_SUSTAIN:    cfg_reg.sustain    <= cfg_wdata;
                rfkey_pkg::REG_HOLD_START: cfg_reg.hold_start <= cfg_wdata;
                rfkey_pkg::REG_PERIOD:     cfg_reg.period     <= cfg_wdata;
                rfkey_pkg::REG_DEBOUNCE:   cfg_reg.debounce   <= cfg_wdata[7:0];
                rfkey_pkg::REG_CODE_UP:    cfg_reg.code[0]    <= cfg_wdata[7:0];
                rfkey_pkg::REG_CODE_DOWN:  cfg_reg.code[1]    <= cfg_wdata[7:0];
                rfkey_pkg::REG_CODE_POWER: cfg_reg.code[2]    <= cfg_wdata[7:0];
                rfkey_pkg::REG_CODE_MODE:  cfg_reg.code[3]    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/rfkey_engine.sv */
module rfkey_engine #(
    parameter int TIMER_WIDTH = rfkey_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                msg_valid,
    input  logic [rfkey_pkg::CODE_WIDTH-1:0]    key_code,
    input  rfkey_pkg::rfkey_cfg_t               cfg,
    input  logic                                buf_free,
    output logic                                res_valid,
    output rfkey_pkg::rfkey_res_t               res
);

    localparam int CW = (TIMER_WIDTH > rfkey_pkg::CFG_WIDTH) ? TIMER_WIDTH
                                                              : rfkey_pkg::CFG_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    typedef logic [TIMER_WIDTH-1:0] tmr_t;
    typedef logic [rfkey_pkg::KEY_WIDTH-1:0] key_t;

    // input register
    logic                               in_valid_reg;
    logic                               msg_valid_reg;
    logic [rfkey_pkg::CODE_WIDTH-1:0]   key_code_reg;

    // block state
    key_t                               active_key_reg, active_key_next;
    tmr_t                               sustain_left_reg, sustain_left_next;
    tmr_t                               held_ticks_reg, held_ticks_next;
    tmr_t                               repeat_timer_reg, repeat_timer_next;
    key_t                               candidate_key_reg, candidate_key_next;
    logic [rfkey_pkg::CODE_WIDTH-1:0]   match_count_reg, match_count_next;

    logic       commit;
    key_t       key;
    tmr_t       sustain_load;
    logic [CW-1:0] sustain_ext;
    tmr_t       ht, rt;
    logic       hold;
    logic [1:0] n;
    rfkey_pkg::rfkey_event_t ev0, ev1;

    assign sustain_ext  = CW'(cfg.sustain);
    assign sustain_load = (sustain_ext > CW'(TMAX)) ? TMAX : TIMER_WIDTH'(sustain_ext);

    // first configured code wins
    always_comb begin
        if (key_code_reg == cfg.code[0])      key = rfkey_pkg::KEY_UP;
        else if (key_code_reg == cfg.code[1]) key = rfkey_pkg::KEY_DOWN;
        else if (key_code_reg == cfg.code[2]) key = rfkey_pkg::KEY_POWER;
        else if (key_code_reg == cfg.code[3]) key = rfkey_pkg::KEY_MODE;
        else                                  key = rfkey_pkg::KEY_NONE;
    end

    always_comb begin
        active_key_next    = active_key_reg;
        sustain_left_next  = sustain_left_reg;
        held_ticks_next    = held_ticks_reg;
        repeat_timer_next  = repeat_timer_reg;
        candidate_key_next = candidate_key_reg;
        match_count_next   = match_count_reg;
        n   = 2'd0;
        ev0 = '0;
        ev1 = '0;
        ht  = '0;
        rt  = '0;
        hold = 1'b0;

        // reception and debounce
        if (msg_valid_reg) begin
            if (key != rfkey_pkg::KEY_NONE) begin
                if (key == candidate_key_reg) begin
                    if (match_count_reg < cfg.debounce)
                        match_count_next = match_count_reg + 8'd1;
                end else begin
                    candidate_key_next = key;
                    match_count_next   = 8'd1;
                end
                if (match_count_next >= cfg.debounce) begin
                    if (active_key_reg == rfkey_pkg::KEY_NONE) begin
                        ev0 = '{key_id: key, event_kind: rfkey_pkg::EV_PRESS, last: 1'b0};
                        n   = 2'd1;
                        active_key_next   = key;
                        held_ticks_next   = '0;
                        repeat_timer_next = '0;
                    end else if (key != active_key_reg) begin
                        ev0 = '{key_id: active_key_reg, event_kind: rfkey_pkg::EV_RELEASE,
                                last: 1'b0};
                        ev1 = '{key_id: key, event_kind: rfkey_pkg::EV_PRESS, last: 1'b0};
                        n   = 2'd2;
                        active_key_next   = key;
                        held_ticks_next   = '0;
                        repeat_timer_next = '0;
                    end
                end
                sustain_left_next = sustain_load;
            end else begin
                candidate_key_next = rfkey_pkg::KEY_NONE;
                match_count_next   = '0;
            end
        end

        // countdown step
        if (active_key_next != rfkey_pkg::KEY_NONE) begin
            if (sustain_left_next != '0) begin
                ht = (held_ticks_next == TMAX) ? TMAX : held_ticks_next + 1'b1;
                rt = repeat_timer_next;
                if (CW'(ht) >= CW'(cfg.hold_start)) begin
                    rt = (rt == TMAX) ? TMAX : rt + 1'b1;
                    if (CW'(rt) >= CW'(cfg.period)) begin
                        rt   = '0;
                        hold = 1'b1;
                    end
                end
                // a third event would not fit: the step waits for the next tick
                if (!(hold && n == 2'd2)) begin
                    sustain_left_next = sustain_left_next - 1'b1;
                    held_ticks_next   = ht;
                    repeat_timer_next = rt;
                    if (hold) begin
                        if (n == 2'd0)
                            ev0 = '{key_id: active_key_next, event_kind: rfkey_pkg::EV_HOLD,
                                    last: 1'b0};
                        else
                            ev1 = '{key_id: active_key_next, event_kind: rfkey_pkg::EV_HOLD,
                                    last: 1'b0};
                        n = n + 2'd1;
                    end
                end
            end else if (n != 2'd2) begin
                candidate_key_next = rfkey_pkg::KEY_NONE;
                match_count_next   = '0;
                if (n == 2'd0)
                    ev0 = '{key_id: active_key_next, event_kind: rfkey_pkg::EV_RELEASE,
                            last: 1'b0};
                else
                    ev1 = '{key_id: active_key_next, event_kind: rfkey_pkg::EV_RELEASE,
                            last: 1'b0};
                n = n + 2'd1;
                active_key_next = rfkey_pkg::KEY_NONE;
                held_ticks_next = '0;
            end
        end

        if (n == 2'd1) ev0.last = 1'b1;
        if (n == 2'd2) ev1.last = 1'b1;
    end

    // an item with no events never waits for the output side
    assign commit    = in_valid_reg && ((n == 2'd0) || buf_free);
    assign s_tready  = !in_valid_reg || commit;
    assign res_valid = commit && (n != 2'd0);
    assign res       = '{count: n, ev0: ev0, ev1: ev1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            msg_valid_reg <= msg_valid;
            key_code_reg  <= key_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_key_reg    <= rfkey_pkg::KEY_NONE;
            sustain_left_reg  <= '0;
            held_ticks_reg    <= '0;
            repeat_timer_reg  <= '0;
            candidate_key_reg <= rfkey_pkg::KEY_NONE;
            match_count_reg   <= '0;
        end else if (commit) begin
            active_key_reg    <= active_key_next;
            sustain_left_reg  <= sustain_left_next;
            held_ticks_reg    <= held_ticks_next;
            repeat_timer_reg  <= repeat_timer_next;
            candidate_key_reg <= candidate_key_next;
            match_count_reg   <= match_count_next;
        end
    end

endmodule

/* sv/rfkey_out.sv */
module rfkey_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                res_valid,
    input  rfkey_pkg::rfkey_res_t               res,
    output logic                                buf_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output rfkey_pkg::rfkey_event_t             m_ev
);

    logic [1:0]              cnt_reg, cnt_next;
    rfkey_pkg::rfkey_event_t slot0_reg, slot1_reg;
    logic                    pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_ev     = slot0_reg;
    assign pop      = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        if (res_valid)
            cnt_next = res.count;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            slot0_reg <= res.ev0;
            slot1_reg <= res.ev1;
        end else if (pop) begin
            // second event of the tick moves up
            slot0_reg <= slot1_reg;
        end
    end

endmodule

/* sv/rf_key_press_hold_repeat_core.sv */
// data path: an item is registered at acceptance, its events are computed from the
//   input register and loaded into the output buffer once it is free, and the
//   first one shows on m_tvalid from the output buffer
// throughput: one item per cycle while ticks give at most one event and m_tready
//   is high; a tick with two events fills the two-entry output buffer, which must drain first
// reset: synchronous, active low; clears key state and loads default registers
module rf_key_press_hold_repeat_core #(
    parameter int TIMER_WIDTH = rfkey_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // key_code
    input  logic [0:0]                          s_tuser,   // msg_valid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // key_id, zero fill
    output logic [1:0]                          m_tuser,   // event_kind
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [rfkey_pkg::REG_IDX_WIDTH-1:0] cfg_index,
    input  logic [rfkey_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

    rfkey_pkg::rfkey_cfg_t   cfg;
    rfkey_pkg::rfkey_res_t   res;
    rfkey_pkg::rfkey_event_t m_ev;
    logic                    res_valid;
    logic                    buf_free;

    rfkey_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rfkey_engine #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .msg_valid (s_tuser[0]),
        .key_code  (s_tdata),
        .cfg       (cfg),
        .buf_free  (buf_free),
        .res_valid (res_valid),
        .res       (res)
    );

    rfkey_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .buf_free  (buf_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_ev      (m_ev)
    );

    assign m_tdata = {5'd0, m_ev.key_id};
    assign m_tuser = m_ev.event_kind;
    assign m_tlast = m_ev.last;

endmodule

/* sv/rfkey_chk.sv */
module rfkey_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // both events of a tick are buffered together, so the second follows at once
    a_pair_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("second event of a tick not ready");

    // a release that is not last is a key switch and a press follows
    a_switch_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser == rfkey_pkg::EV_RELEASE
        |=> m_tuser == rfkey_pkg::EV_PRESS)
        else $error("key switch release not followed by press");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != 3'd0) && (m_tdata[2:0] <= 3'd4)
                     && (m_tdata[7:3] == 5'd0) && (m_tuser != 2'd3))
        else $error("event outside key or kind range");

    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled event changed");

endmodule

bind rf_key_press_hold_repeat_core rfkey_chk u_rfkey_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
